FILE: sv/triac_phase_angle_firing_unit_assert.svh
// ---------------------------------------------------------------------------
// triac phase angle firing unit assertion macros
// clocked property macros with and without a reset disable
// ---------------------------------------------------------------------------
`ifndef TRIAC_PHASE_ANGLE_FIRING_UNIT_ASSERT_SVH
`define TRIAC_PHASE_ANGLE_FIRING_UNIT_ASSERT_SVH

// property checked only outside reset
`define TPAF_ASSERT_RST(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tpaf assertion failed");

// property checked on every edge, reset included
`define TPAF_ASSERT_ALL(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("tpaf assertion failed");

`endif

FILE: sv/tpaf_pkg.sv
// ---------------------------------------------------------------------------
// tpaf_pkg
// shared widths, register indexes and constants of the triac firing unit
// ---------------------------------------------------------------------------
package tpaf_pkg;

  localparam int TIME_BITS_DEF = 24;
  localparam int PCT_W         = 7;
  localparam int PW_W          = 10;
  localparam int HP_W          = 24;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 10;

  localparam logic [CFG_IDX_W-1:0] REG_POWER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE = 2'd1;

  localparam logic [PCT_W-1:0] FULL_PCT        = 7'd100;
  localparam logic [PW_W-1:0]  PULSE_AT_RESET  = 10'd10;
  localparam int               PERIOD_AT_RESET = 8300;
  localparam logic [HP_W-1:0]  HP_MAX          = '1;

  // configuration side effects on the tick logic
  typedef struct packed {
    logic drop_run;
    logic zero_delay;
    logic load_delay;
  } cfg_evt_t;

endpackage

FILE: sv/tpaf_in_if.sv
// ---------------------------------------------------------------------------
// tpaf_in_if
// tick channel carrying the zero-cross edge flag
// ---------------------------------------------------------------------------
interface tpaf_in_if;
  logic valid;
  logic ready;
  logic zero_cross_edge;

  modport source (output valid, output zero_cross_edge, input ready);
  modport sink   (input valid, input zero_cross_edge, output ready);
endinterface

FILE: sv/tpaf_out_if.sv
// ---------------------------------------------------------------------------
// tpaf_out_if
// result channel carrying gate level and measured half period
// ---------------------------------------------------------------------------
interface tpaf_out_if;
  logic                      valid;
  logic                      ready;
  logic                      triac_gate;
  logic [tpaf_pkg::HP_W-1:0] half_period;

  modport source (output valid, output triac_gate, output half_period, input ready);
  modport sink   (input valid, input triac_gate, input half_period, output ready);
endinterface

FILE: sv/tpaf_cfg_if.sv
// ---------------------------------------------------------------------------
// tpaf_cfg_if
// register write channel
// ---------------------------------------------------------------------------
interface tpaf_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [tpaf_pkg::CFG_IDX_W-1:0]  index;
  logic [tpaf_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: sv/tpaf_delay_div.sv
// ---------------------------------------------------------------------------
// tpaf_delay_div
// firing delay = period * k / 100 from the period split into quotient and
// remainder by 100, in steps: multiply, reciprocal scale and add, load
// ---------------------------------------------------------------------------
module tpaf_delay_div #(
  parameter int TIME_BITS = tpaf_pkg::TIME_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [tpaf_pkg::PCT_W-1:0] start_k,
  input  logic [TIME_BITS-1:0]       period_q,
  input  logic [tpaf_pkg::PCT_W-1:0] period_rem,
  output logic                       busy,
  output logic                       done,
  output logic [TIME_BITS-1:0]       delay
);

  localparam int PCT_W  = tpaf_pkg::PCT_W;
  localparam int QK_W   = TIME_BITS + PCT_W;
  localparam int RK_W   = 2 * PCT_W;
  localparam int RCP_SH = 21;
  localparam int RCP_W  = 15;
  localparam int SC_W   = RK_W + RCP_W;
  // rounded-up reciprocal of 100, exact for every remainder times k
  localparam logic [RCP_W-1:0] RCP =
    RCP_W'(((2 ** RCP_SH) + int'(tpaf_pkg::FULL_PCT) - 1) / int'(tpaf_pkg::FULL_PCT));

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_DONE} state_t;

  state_t               state_r;
  logic [PCT_W-1:0]     k_r;
  logic [TIME_BITS-1:0] qk_r;
  logic [RK_W-1:0]      rk_r;
  logic [TIME_BITS-1:0] delay_r;

  logic [QK_W-1:0]      qk_full;
  logic [RK_W-1:0]      rk_full;
  logic [SC_W-1:0]      rk_scaled;
  logic [PCT_W-1:0]     rk_quo;
  logic [TIME_BITS-1:0] delay_nxt;

  assign qk_full   = {{PCT_W{1'b0}}, period_q} * {{TIME_BITS{1'b0}}, k_r};
  assign rk_full   = {{PCT_W{1'b0}}, period_rem} * {{PCT_W{1'b0}}, k_r};
  assign rk_scaled = {{RCP_W{1'b0}}, rk_r} * {{RK_W{1'b0}}, RCP};
  assign rk_quo    = rk_scaled[RCP_SH +: PCT_W];
  assign delay_nxt = qk_r + {{(TIME_BITS-PCT_W){1'b0}}, rk_quo};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            k_r     <= start_k;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          qk_r    <= qk_full[TIME_BITS-1:0];
          rk_r    <= rk_full;
          state_r <= S_DIV;
        end
        S_DIV: begin
          delay_r <= delay_nxt;
          state_r <= S_DONE;
        end
        S_DONE: begin
          state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy  = state_r != S_IDLE;
  assign done  = state_r == S_DONE;
  assign delay = delay_r;

endmodule

FILE: sv/tpaf_tick.sv
// ---------------------------------------------------------------------------
// tpaf_tick
// per-tick period measurement, countdown, gate pulse and result register
// ---------------------------------------------------------------------------
module tpaf_tick #(
  parameter int TIME_BITS = tpaf_pkg::TIME_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step,
  input  logic                       take,
  input  logic                       zero_cross_edge,
  input  logic [tpaf_pkg::PCT_W-1:0] power,
  input  logic [tpaf_pkg::PW_W-1:0]  pulse_width,
  input  tpaf_pkg::cfg_evt_t         evt,
  input  logic [TIME_BITS-1:0]       delay_val,
  output logic                       out_valid,
  output logic                       triac_gate,
  output logic [tpaf_pkg::HP_W-1:0]  half_period,
  output logic [TIME_BITS-1:0]       period_q,
  output logic [tpaf_pkg::PCT_W-1:0] period_rem
);

  localparam int HP_W  = tpaf_pkg::HP_W;
  localparam int PCT_W = tpaf_pkg::PCT_W;
  localparam logic [PCT_W-1:0] REM_LAST = tpaf_pkg::FULL_PCT - 1'b1;
  localparam logic [TIME_BITS-1:0] PER_Q_RST =
    TIME_BITS'(tpaf_pkg::PERIOD_AT_RESET / int'(tpaf_pkg::FULL_PCT));
  localparam logic [PCT_W-1:0] PER_RM_RST =
    PCT_W'(tpaf_pkg::PERIOD_AT_RESET % int'(tpaf_pkg::FULL_PCT));

  logic [TIME_BITS-1:0]       since_r,   since_nxt;
  logic [TIME_BITS-1:0]       since_q_r, since_q_nxt;
  logic [PCT_W-1:0]           since_rm_r, since_rm_nxt;
  logic                       seen_r,    seen_nxt;
  logic [TIME_BITS-1:0]       period_r,  period_nxt;
  logic [TIME_BITS-1:0]       per_q_r,   per_q_nxt;
  logic [PCT_W-1:0]           per_rm_r,  per_rm_nxt;
  logic [TIME_BITS-1:0]       fire_dly_r, fire_dly_nxt;
  logic [TIME_BITS-1:0]       dly_rem_r, dly_rem_nxt;
  logic                       armed_r,   armed_nxt;
  logic [tpaf_pkg::PW_W-1:0]  pulse_r,   pulse_nxt;
  logic                       gate;
  logic [HP_W-1:0]            half_sat;

  logic                       out_valid_r;
  logic                       gate_r;
  logic [HP_W-1:0]            half_r;

  always_comb begin
    since_nxt    = since_r;
    since_q_nxt  = since_q_r;
    since_rm_nxt = since_rm_r;
    seen_nxt     = seen_r;
    period_nxt   = period_r;
    per_q_nxt    = per_q_r;
    per_rm_nxt   = per_rm_r;
    fire_dly_nxt = fire_dly_r;
    dly_rem_nxt  = dly_rem_r;
    armed_nxt    = armed_r;
    pulse_nxt    = pulse_r;
    gate         = 1'b0;
    if (step) begin
      if (since_r != '1) begin
        since_nxt = since_r + 1'b1;
        // running quotient and remainder of the tick count by 100
        if (since_rm_r == REM_LAST) begin
          since_rm_nxt = '0;
          since_q_nxt  = since_q_r + 1'b1;
        end else begin
          since_rm_nxt = since_rm_r + 1'b1;
        end
      end
      if (power == tpaf_pkg::FULL_PCT) begin
        gate = 1'b1;
      end else if (power != '0) begin
        if (armed_r) begin
          if (dly_rem_r != '0) begin
            dly_rem_nxt = dly_rem_r - 1'b1;
          end
          if (dly_rem_nxt == '0) begin
            armed_nxt = 1'b0;
            pulse_nxt = pulse_width;
          end
        end
        if (zero_cross_edge) begin
          if (seen_r) begin
            period_nxt = since_nxt;
            per_q_nxt  = since_q_nxt;
            per_rm_nxt = since_rm_nxt;
          end
          seen_nxt     = 1'b1;
          since_nxt    = '0;
          since_q_nxt  = '0;
          since_rm_nxt = '0;
          if (fire_dly_r == '0) begin
            pulse_nxt = pulse_width;
          end else if (fire_dly_r < period_nxt && !armed_nxt) begin
            dly_rem_nxt = fire_dly_r;
            armed_nxt   = 1'b1;
          end
        end
        gate = pulse_nxt != '0;
        if (gate) begin
          pulse_nxt = pulse_nxt - 1'b1;
        end
      end
    end
    if (evt.drop_run) begin
      armed_nxt   = 1'b0;
      dly_rem_nxt = '0;
      pulse_nxt   = '0;
    end
    if (evt.zero_delay) begin
      fire_dly_nxt = '0;
    end
    if (evt.load_delay) begin
      fire_dly_nxt = delay_val;
    end
  end

  generate
    if (TIME_BITS > HP_W) begin : g_sat
      assign half_sat = (period_nxt > TIME_BITS'(tpaf_pkg::HP_MAX)) ?
                        tpaf_pkg::HP_MAX : period_nxt[HP_W-1:0];
    end else begin : g_ext
      assign half_sat = HP_W'(period_nxt);
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      since_r     <= '0;
      since_q_r   <= '0;
      since_rm_r  <= '0;
      seen_r      <= 1'b0;
      period_r    <= TIME_BITS'(tpaf_pkg::PERIOD_AT_RESET);
      per_q_r     <= PER_Q_RST;
      per_rm_r    <= PER_RM_RST;
      fire_dly_r  <= '0;
      dly_rem_r   <= '0;
      armed_r     <= 1'b0;
      pulse_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      since_r    <= since_nxt;
      since_q_r  <= since_q_nxt;
      since_rm_r <= since_rm_nxt;
      seen_r     <= seen_nxt;
      period_r   <= period_nxt;
      per_q_r    <= per_q_nxt;
      per_rm_r   <= per_rm_nxt;
      fire_dly_r <= fire_dly_nxt;
      dly_rem_r  <= dly_rem_nxt;
      armed_r    <= armed_nxt;
      pulse_r    <= pulse_nxt;
      if (step) begin
        out_valid_r <= 1'b1;
      end else if (take) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      gate_r <= gate;
      half_r <= half_sat;
    end
  end

  assign out_valid   = out_valid_r;
  assign triac_gate  = gate_r;
  assign half_period = half_r;
  assign period_q    = per_q_r;
  assign period_rem  = per_rm_r;

endmodule

FILE: sv/triac_phase_angle_firing_unit.sv
// ---------------------------------------------------------------------------
// triac_phase_angle_firing_unit
// result: registered, valid in the cycle after the tick transaction
// throughput: one tick per cycle, stalled by cfg writes, divider or sink
// power write of 1..99 percent: busy while computing the firing delay
// reset: synchronous active low, period 8300, power 0, pulse width 10
// ---------------------------------------------------------------------------
module triac_phase_angle_firing_unit #(
  parameter int TIME_BITS = tpaf_pkg::TIME_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  tpaf_in_if.sink     in_ch,
  tpaf_out_if.source  out_ch,
  tpaf_cfg_if.sink    cfg_ch
);

  localparam int PCT_W = tpaf_pkg::PCT_W;
  localparam int PW_W  = tpaf_pkg::PW_W;

  logic [PCT_W-1:0]     power_r;
  logic [PW_W-1:0]      pulse_w_r;

  logic                 cfg_acc;
  logic                 wr_power;
  logic                 wr_pulse;
  logic [PCT_W-1:0]     pct_raw;
  logic [PCT_W-1:0]     pct;
  logic                 pct_hold;
  logic [PCT_W-1:0]     div_k;

  logic                 div_busy;
  logic                 div_done;
  logic [TIME_BITS-1:0] div_delay;
  logic [TIME_BITS-1:0] period_q;
  logic [PCT_W-1:0]     period_rem;

  tpaf_pkg::cfg_evt_t   evt;
  logic                 step;
  logic                 take;
  logic                 out_valid;

  assign cfg_acc  = cfg_ch.valid && cfg_ch.ready;
  assign wr_power = cfg_acc && (cfg_ch.index == tpaf_pkg::REG_POWER);
  assign wr_pulse = cfg_acc && (cfg_ch.index == tpaf_pkg::REG_PULSE);
  assign pct_raw  = cfg_ch.data[PCT_W-1:0];
  assign pct      = (pct_raw > tpaf_pkg::FULL_PCT) ? tpaf_pkg::FULL_PCT : pct_raw;
  assign pct_hold = (pct == tpaf_pkg::FULL_PCT) || (pct == '0);
  assign div_k    = tpaf_pkg::FULL_PCT - pct;

  assign evt.drop_run   = wr_power && pct_hold;
  assign evt.zero_delay = wr_power && (pct == tpaf_pkg::FULL_PCT);
  assign evt.load_delay = div_done;

  // config transaction takes priority over a tick in the same cycle
  assign cfg_ch.ready = !div_busy;
  assign in_ch.ready  = !div_busy && !cfg_ch.valid && (!out_valid || out_ch.ready);
  assign step         = in_ch.valid && in_ch.ready;
  assign take         = out_valid && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      power_r   <= '0;
      pulse_w_r <= tpaf_pkg::PULSE_AT_RESET;
    end else begin
      if (wr_power) begin
        power_r <= pct;
      end
      if (wr_pulse) begin
        pulse_w_r <= cfg_ch.data[PW_W-1:0];
      end
    end
  end

  tpaf_delay_div #(
    .TIME_BITS (TIME_BITS)
  ) u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (wr_power && !pct_hold),
    .start_k    (div_k),
    .period_q   (period_q),
    .period_rem (period_rem),
    .busy       (div_busy),
    .done       (div_done),
    .delay      (div_delay)
  );

  tpaf_tick #(
    .TIME_BITS (TIME_BITS)
  ) u_tick (
    .clk             (clk),
    .rst_n           (rst_n),
    .step            (step),
    .take            (take),
    .zero_cross_edge (in_ch.zero_cross_edge),
    .power           (power_r),
    .pulse_width     (pulse_w_r),
    .evt             (evt),
    .delay_val       (div_delay),
    .out_valid       (out_valid),
    .triac_gate      (out_ch.triac_gate),
    .half_period     (out_ch.half_period),
    .period_q        (period_q),
    .period_rem      (period_rem)
  );

  assign out_ch.valid = out_valid;

endmodule

FILE: sv/tpaf_checker.sv
// ---------------------------------------------------------------------------
// tpaf_checker
// port-level checks of the triac firing unit, bound to the top level
// ---------------------------------------------------------------------------
`include "triac_phase_angle_firing_unit_assert.svh"

module tpaf_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic                            out_triac_gate,
  input logic [tpaf_pkg::HP_W-1:0]       out_half_period,
  input logic                            cfg_valid,
  input logic                            cfg_ready,
  input logic [tpaf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [tpaf_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic tick_acc;
  logic div_write;

  assign tick_acc  = in_valid && in_ready;
  assign div_write = cfg_valid && cfg_ready && (cfg_index == tpaf_pkg::REG_POWER) &&
                     (cfg_data[tpaf_pkg::PCT_W-1:0] != '0) &&
                     (cfg_data[tpaf_pkg::PCT_W-1:0] < tpaf_pkg::FULL_PCT);

  // stalled result holds
  `TPAF_ASSERT_RST(a_out_hold, clk, rst_n,
    out_valid && !out_ready |=> out_valid && $stable(out_triac_gate) && $stable(out_half_period))

  // every tick transaction yields a result next cycle
  `TPAF_ASSERT_RST(a_tick_result, clk, rst_n, tick_acc |=> out_valid)

  // delay computation blocks ticks and further writes
  `TPAF_ASSERT_RST(a_div_block, clk, rst_n, div_write |=> !in_ready && !cfg_ready)

  // reset empties the result register
  `TPAF_ASSERT_ALL(a_reset_empty, clk, !rst_n |=> !out_valid)

endmodule

bind triac_phase_angle_firing_unit tpaf_checker u_tpaf_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_triac_gate  (out_ch.triac_gate),
  .out_half_period (out_ch.half_period),
  .cfg_valid       (cfg_ch.valid),
  .cfg_ready       (cfg_ch.ready),
  .cfg_index       (cfg_ch.index),
  .cfg_data        (cfg_ch.data)
);
